>>> rtl/core/deq_pkg.sv
package deq_pkg;

	// Fixed widths of the channel fields.
	localparam int CMD_W   = 3;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 6;
	localparam int ELEM_W  = 32;
	localparam int ST_W    = 2;
	localparam int COUNT_W = 7;

	// Defaults for the top-level parameters.
	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ       = 3'd4,
		CMD_CLEAR      = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Per-command result from the control logic, minus the element itself.
	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic                 is_empty;
		logic                 rd;
	} deq_result_t;

endpackage

>>> rtl/core/deq_if.sv
interface deq_cmd_if import deq_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [VAL_W-1:0] value;
	logic [IDX_W-1:0] index;

	modport source (output valid, command, value, index, input ready);
	modport sink (input valid, command, value, index, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [ELEM_W-1:0]  element;
	logic [ST_W-1:0]    status;
	logic [COUNT_W-1:0] count;
	logic               is_empty;

	modport source (output valid, element, status, count, is_empty, input ready);
	modport sink (input valid, element, status, count, is_empty, output ready);
endinterface

>>> rtl/core/double_ended_queue.sv
// Channel  Role    Beat contents
// -------  ------  -----------------------------------------
// cmd      sink    command, value, index
// rsp      source  element, status, count, is_empty
//
// One command per cycle while rsp is taken; each response passes the read stage, then the output register.
// The rate is set by the single-port ring store: one read or one write per command.
// Reset clears the front pointer and count; the store needs no clearing pass.
// A stalled rsp fills the output register and then the read stage, after which
// cmd.ready drops until the output register is taken.
module double_ended_queue import deq_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_cmd_if.sink   cmd,
	deq_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                  accept;
	logic                  s1_adv;
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_addr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata_q;
	logic [ELEM_W+DATA_WIDTH-1:0] rd_ext;
	deq_result_t           result;
	deq_result_t           result_s1;
	logic                  valid_s1;
	logic                  out_valid_q;
	logic [ELEM_W-1:0]     element_q;
	deq_result_t           out_res_q;

	assign s1_adv    = !out_valid_q || rsp.ready;
	assign cmd.ready = !valid_s1 || s1_adv;
	assign accept    = cmd.valid && cmd.ready;

	deq_ctrl #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.AW        (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (cmd.command),
		.value    (cmd.value),
		.index    (cmd.index),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.result   (result)
	);

	deq_ring_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_WIDTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.re     (mem_re),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata_q(mem_rdata_q)
	);

	// Read stage valid: waits here while the store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Read stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
		end
	end

	assign rd_ext = {{ELEM_W{1'b0}}, mem_rdata_q};

	// Output register: the element is taken from the store only for reads and pops.
	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_res_q <= result_s1;
			element_q <= result_s1.rd ? rd_ext[ELEM_W-1:0] : '0;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.element  = element_q;
	assign rsp.status   = out_res_q.status;
	assign rsp.count    = out_res_q.count;
	assign rsp.is_empty = out_res_q.is_empty;

endmodule

>>> rtl/core/deq_ring_mem.sv
module deq_ring_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

>>> rtl/core/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int AW         = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [CMD_W-1:0]      command,
	input  logic [VAL_W-1:0]      value,
	input  logic [IDX_W-1:0]      index,
	output logic                  mem_we,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_addr,
	output logic [DATA_WIDTH-1:0] mem_wdata,
	output deq_result_t           result
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [AW:0]   CAP_A = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);

	logic [AW-1:0] front_q, front_n;
	logic [CW-1:0] count_q, count_n;
	logic [CW-1:0] cnt_m1;
	logic [CMPW-1:0] idx_ext, cnt_ext;
	logic [AW-1:0] pos_back, pos_last, pos_idx, pos_next, pos_prev;
	logic [VAL_W+DATA_WIDTH-1:0] val_ext;
	logic full, empty;

	// Offset from the front into the ring; the sum is wrapped by one subtraction of the capacity.
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CAP_A) begin
			s = s - CAP_A;
		end
		return s[AW-1:0];
	endfunction

	assign full     = (count_q == CAP_C);
	assign empty    = (count_q == '0);
	assign cnt_m1   = count_q - CW'(1);
	assign idx_ext  = CMPW'(index);
	assign cnt_ext  = CMPW'(count_q);
	assign pos_back = ring_add(front_q, count_q[AW-1:0]);
	assign pos_last = ring_add(front_q, cnt_m1[AW-1:0]);
	assign pos_idx  = ring_add(front_q, idx_ext[AW-1:0]);
	assign pos_next = ring_add(front_q, AW'(1));
	assign pos_prev = (front_q == '0) ? LAST : front_q - AW'(1);
	assign val_ext  = {{DATA_WIDTH{1'b0}}, value};
	assign mem_wdata = val_ext[DATA_WIDTH-1:0];

	// Command decode: pointer and count updates plus at most one store access.
	always_comb begin
		front_n         = front_q;
		count_n         = count_q;
		mem_we          = 1'b0;
		mem_re          = 1'b0;
		mem_addr        = pos_back;
		result.status   = ST_OK;
		result.rd       = 1'b0;
		unique case (cmd_t'(command))
			CMD_PUSH_BACK: begin
				if (full) begin
					result.status = ST_FULL;
				end else begin
					mem_we  = accept;
					count_n = count_q + CW'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				mem_addr = pos_prev;
				if (full) begin
					result.status = ST_FULL;
				end else begin
					mem_we  = accept;
					front_n = pos_prev;
					count_n = count_q + CW'(1);
				end
			end
			CMD_POP_BACK: begin
				mem_addr = pos_last;
				if (empty) begin
					result.status = ST_EMPTY;
				end else begin
					mem_re    = accept;
					result.rd = 1'b1;
					count_n   = cnt_m1;
				end
			end
			CMD_POP_FRONT: begin
				mem_addr = front_q;
				if (empty) begin
					result.status = ST_EMPTY;
				end else begin
					mem_re    = accept;
					result.rd = 1'b1;
					front_n   = pos_next;
					count_n   = cnt_m1;
				end
			end
			CMD_READ: begin
				mem_addr = pos_idx;
				if (idx_ext >= cnt_ext) begin
					result.status = ST_RANGE;
				end else begin
					mem_re    = accept;
					result.rd = 1'b1;
				end
			end
			CMD_CLEAR: begin
				front_n = '0;
				count_n = '0;
			end
			default: begin
			end
		endcase
		// Count and empty flag as they stand after this command.
		result.count    = COUNT_W'(count_n);
		result.is_empty = (count_n == '0);
	end

	// Front pointer and count load their next values on every accepted command beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_n;
			count_q <= count_n;
		end
	end

endmodule

>>> rtl/core/deq_checker.sv
module deq_checker import deq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [ELEM_W-1:0]  rsp_element,
	input logic [ST_W-1:0]    rsp_status,
	input logic [COUNT_W-1:0] rsp_count,
	input logic               rsp_is_empty
);

	// An empty queue always reports a zero count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_empty |-> rsp_count == '0)
		else $error("empty flag set with nonzero count");

	// A pop that found nothing leaves the queue empty and returns no element.
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_element == '0)
		else $error("empty-pop beat is inconsistent");

	// A rejected push means the queue is full, so it reports nonempty, and no element is returned.
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> !rsp_is_empty && rsp_element == '0)
		else $error("full-push beat is inconsistent");

	// A stalled response beat holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element)
			&& $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_is_empty))
		else $error("response beat changed while stalled");

	// With no response waiting, the queue always takes a command beat.
	a_cmd_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> cmd_ready)
		else $error("command refused with no response waiting");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_element (rsp.element),
	.rsp_status  (rsp.status),
	.rsp_count   (rsp.count),
	.rsp_is_empty(rsp.is_empty)
);
